/* rtl/core/qesm_pkg.sv */
package qesm_pkg;

    // Sizing
    localparam int CHANNELS    = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W      = COUNT_WIDTH + 17;   // signed count x unsigned 16-bit scale
    localparam int SPEED_W     = PROD_W - 8;         // product after the Q8 shift
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX =
        COUNT_WIDTH'((64'd1 << (COUNT_WIDTH - 1)) - 64'd1);
    localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = -COUNT_MAX;

    // Function codes of an input word
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd1;

    localparam logic [15:0] SCALE_RESET = 16'd36009;
    localparam logic [14:0] LIMIT_RESET = 15'd25600;

    typedef struct packed {
        logic       func;
        logic [1:0] channel;
        logic       a_level;
        logic       b_level;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         out_channel;
        logic signed [15:0] count_delta;
        logic signed [15:0] speed_q8;
        logic               last;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                edge_upd;   // apply the accepted edge word to its count
        logic                mul_load;   // register count x scale, clear the count
        logic                out_load;   // shift, clamp and load the output register
        logic [CH_IDX_W-1:0] idx;        // channel being reported
        logic                last;       // final channel of the tick
    } t_cmd;

    typedef struct packed {
        logic out_free;                  // output register can take a word this cycle
    } t_status;

endpackage

/* rtl/core/qesm_ctrl.sv */
module qesm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_func,
    output logic             o_in_ready,
    input  qesm_pkg::t_status i_sts,
    output qesm_pkg::t_cmd    o_cmd
);
    import qesm_pkg::*;

    localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(CHANNELS - 1);

    t_state              r_state, n_state;
    logic [CH_IDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.idx      = r_idx;
        o_cmd.last     = (r_idx == LAST_IDX);
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_func == FUNC_TICK) begin
                        n_state = ST_MUL;
                    end else begin
                        o_cmd.edge_upd = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_MUL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_idle_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_idx == '0))
        else $error("channel index not zero while idle");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output load while output register busy");

    a_mul_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_OUT))
        else $error("product stage not followed by output stage");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && !o_cmd.last) |=> (r_state == ST_MUL))
        else $error("tick ended before the last channel");

endmodule

/* rtl/core/qesm_dpath.sv */
module qesm_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qesm_pkg::t_cmd                       i_cmd,
    output qesm_pkg::t_status                    o_sts,
    input  qesm_pkg::t_in_word                   i_in_word,
    input  logic                                 i_cfg_valid,
    input  logic [qesm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qesm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output qesm_pkg::t_out_word                  o_out_word
);
    import qesm_pkg::*;

    logic signed [COUNT_WIDTH-1:0] r_count [CHANNELS];
    logic [15:0]                   r_scale;
    logic [14:0]                   r_limit;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [COUNT_WIDTH-1:0] r_delta;
    logic                          r_out_valid;
    t_out_word                     r_out_word, n_out_word;

    logic [CH_IDX_W-1:0]           edge_idx;
    logic                          edge_ok;
    logic signed [COUNT_WIDTH-1:0] edge_cur, n_edge_count;
    logic signed [PROD_W-1:0]      product;
    logic signed [SPEED_W-1:0]     speed_raw, speed_lim, speed_clamped;

    // Edge: +1 when A equals B, -1 otherwise, held at the saturation bounds
    always_comb begin
        edge_idx = CH_IDX_W'(i_in_word.channel);
        edge_ok  = (32'(i_in_word.channel) < CHANNELS);
        edge_cur = r_count[edge_idx];
        if (i_in_word.a_level == i_in_word.b_level) begin
            n_edge_count = (edge_cur < COUNT_MAX) ? edge_cur + 1'b1 : edge_cur;
        end else begin
            n_edge_count = (edge_cur > COUNT_MIN) ? edge_cur - 1'b1 : edge_cur;
        end
    end

    assign product = $signed(r_count[i_cmd.idx]) * $signed({1'b0, r_scale});

    // Floor shift by 8, then clamp to +/- limit
    always_comb begin
        speed_raw = r_prod[PROD_W-1:8];
        speed_lim = $signed(SPEED_W'(r_limit));
        if (speed_raw > speed_lim) begin
            speed_clamped = speed_lim;
        end else if (speed_raw < -speed_lim) begin
            speed_clamped = -speed_lim;
        end else begin
            speed_clamped = speed_raw;
        end
        n_out_word             = r_out_word;
        n_out_word.out_channel = 2'(i_cmd.idx);
        n_out_word.count_delta = 16'(r_delta);
        n_out_word.speed_q8    = speed_clamped[15:0];
        n_out_word.last        = i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_count[i] <= '0;
            end
            r_scale <= SCALE_RESET;
            r_limit <= LIMIT_RESET;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_SPEED_SCALE) begin
                    r_scale <= i_cfg_data;
                end else if (i_cfg_index == REG_SPEED_LIMIT) begin
                    r_limit <= i_cfg_data[14:0];
                end
            end
            if (i_cmd.edge_upd && edge_ok) begin
                r_count[edge_idx] <= n_edge_count;
            end
            if (i_cmd.mul_load) begin
                r_count[i_cmd.idx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_prod  <= product;
            r_delta <= r_count[i_cmd.idx];
        end
        if (i_cmd.out_load) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out_word;

endmodule

/* rtl/core/quadrature_encoder_speed_meter.sv */
// Four-channel quadrature encoder speed meter.
// Input channel (i_in_valid / o_in_ready / i_in_word): an edge word
// (func = edge) names a channel and carries the A and B levels at an A-phase
// edge; the channel count steps up when A equals B, down otherwise, and
// saturates at +/-32767. A tick word (func = tick) closes the window.
// Output channel (o_out_valid / i_out_ready / o_out_word): per tick one word
// per channel, in channel order: count delta, speed = (delta * scale) >>> 8
// in Q8.8 clamped to +/-limit, and last on the final channel. The count is
// cleared as it is reported. Edge words produce no output.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 speed_scale, index 1
// speed_limit; other indexes are dropped. Always ready; write only when idle.
// Sequencing: an edge word is applied to its channel count as it is accepted.
// A tick steps each channel in channel order through the product register,
// then shift/clamp into the output register. Input is held off while a tick
// runs and is taken again once the last channel's word is loaded.
// A stalled receiver holds the output register and the sequencer waits.
// Reset: counts cleared, registers to scale 36009 and limit 25600, no output.
module quadrature_encoder_speed_meter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  qesm_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output qesm_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qesm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qesm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import qesm_pkg::*;

    t_cmd    cmd;
    t_status sts;

    // Register writes are never stalled, nothing to back-pressure
    assign o_cfg_ready = 1'b1;

    qesm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_word.func),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    qesm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
